>>> rtl/core/word_bucket_sort_by_first_letter_unit_defines.svh
// Assertion macros for the word bucket sort unit.
`ifndef WORD_BUCKET_SORT_BY_FIRST_LETTER_UNIT_DEFINES_SVH
`define WORD_BUCKET_SORT_BY_FIRST_LETTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WBS_ASSERT(lbl, clk, rstn, prop, msg)
`define WBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/wbs_pkg.sv
package wbs_pkg;

    localparam int TEXT_DEPTH = 4096;
    localparam int MAX_WORDS  = 1024;

    localparam int TA_W    = $clog2(TEXT_DEPTH);
    localparam int TP_W    = TA_W + 1;
    localparam int WA_W    = $clog2(MAX_WORDS);
    localparam int WC_W    = WA_W + 1;
    localparam int RANK_W  = 6;
    localparam int RR_W    = RANK_W + 1;
    localparam int ENTRY_W = RANK_W + 2 * TA_W;

    localparam logic [RR_W-1:0] RANK_END = RR_W'(64);

    localparam int LETTER_N   = 52;
    localparam int GROUP_W    = 60;
    localparam int GROUP_LAST = 5;
    localparam int LAST_W     = 2 * RANK_W;
    localparam int CFG_W      = GROUP_LAST * GROUP_W + LAST_W;
    localparam int CIDX_W     = 3;

    localparam logic [CIDX_W-1:0] CFG_IDX_LAST = CIDX_W'(GROUP_LAST);

    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7a;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5a;

    typedef struct packed {
        logic push;
        logic emit_open;
        logic emit_done;
        logic tbl_rd;
        logic next_rank;
        logic next_word;
        logic txt_rd;
        logic emit_letter;
    } ctrl_cmd_t;

    typedef struct packed {
        logic push_req;
        logic pull_req;
        logic out_free;
        logic closed;
        logic rank_done;
        logic word_avail;
        logic match;
    } ctrl_stat_t;

endpackage

>>> rtl/core/wbs_ram.sv
module wbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/core/wbs_ctrl.sv
module wbs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  wbs_pkg::ctrl_stat_t stat,
    output wbs_pkg::ctrl_cmd_t  cmd,
    output logic               s_ready
);
    import wbs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = stat.push_req || stat.out_free;
                if (stat.push_req) begin
                    cmd.push = 1'b1;
                end else if (stat.pull_req && stat.out_free) begin
                    if (stat.closed) begin
                        state_next = ST_SCAN;
                    end else begin
                        cmd.emit_open = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.rank_done) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end else if (stat.word_avail) begin
                    cmd.tbl_rd = 1'b1;
                    state_next = ST_CHK;
                end else begin
                    cmd.next_rank = 1'b1;
                end
            end
            ST_CHK: begin
                if (stat.match) begin
                    cmd.txt_rd = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.next_word = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_EMIT: begin
                cmd.emit_letter = 1'b1;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> rtl/core/wbs_dp.sv
`include "word_bucket_sort_by_first_letter_unit_defines.svh"

module wbs_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wbs_pkg::ctrl_cmd_t          cmd,
    output wbs_pkg::ctrl_stat_t         stat,
    input  logic                        s_valid,
    input  logic                        s_cmd,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_text_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_word_end,
    output logic                        m_all_done,
    output logic                        m_overflowed,
    input  logic                        cfg_we,
    input  logic [wbs_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [wbs_pkg::GROUP_W-1:0] cfg_data
);
    import wbs_pkg::*;

    logic [CFG_W-1:0] rank_cfg_reg;

    logic [WC_W-1:0] word_total_reg, word_total_next;
    logic [TP_W-1:0] write_pos_reg, write_pos_next;
    logic [TP_W-1:0] open_start_reg, open_start_next;
    logic            inside_reg, inside_next;
    logic            drop_reg, drop_next;
    logic            closed_reg, closed_next;
    logic            ovf_reg, ovf_next;
    logic [7:0]      first_reg, first_next;
    logic [RR_W-1:0] read_rank_reg;
    logic [WC_W-1:0] read_word_reg;
    logic [TA_W-1:0] read_off_reg;

    logic            m_valid_reg;
    logic [7:0]      m_byte_reg;
    logic            m_end_reg, m_done_reg, m_ovf_reg;

    logic               txt_we, tbl_we, is_letter;
    logic [TA_W-1:0]    txt_waddr, txt_raddr;
    logic [7:0]         txt_rdata;
    logic [WA_W-1:0]    tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;
    logic [RANK_W-1:0]  ent_rank;
    logic [TA_W-1:0]    ent_start, ent_lenm1;
    logic [5:0]         letter_idx;
    logic [TP_W-1:0]    word_len;
    logic               word_last;

    assign {ent_rank, ent_start, ent_lenm1} = tbl_rdata;

    always_comb begin
        letter_idx = 6'(first_next - CH_LA);
        if (first_next >= CH_UA && first_next <= CH_UZ) begin
            letter_idx = 6'(first_next - CH_UA) + 6'd26;
        end
    end

    assign is_letter = (s_text_byte >= CH_LA && s_text_byte <= CH_LZ)
                    || (s_text_byte >= CH_UA && s_text_byte <= CH_UZ);

    always_comb begin
        word_total_next = closed_reg ? '0 : word_total_reg;
        write_pos_next  = closed_reg ? '0 : write_pos_reg;
        open_start_next = closed_reg ? '0 : open_start_reg;
        inside_next     = closed_reg ? 1'b0 : inside_reg;
        drop_next       = closed_reg ? 1'b0 : drop_reg;
        ovf_next        = closed_reg ? 1'b0 : ovf_reg;
        closed_next     = 1'b0;
        first_next      = first_reg;
        txt_we          = 1'b0;
        txt_waddr       = write_pos_next[TA_W-1:0];
        tbl_we          = 1'b0;
        tbl_waddr       = word_total_next[WA_W-1:0];
        word_len        = '0;
        if (is_letter) begin
            if (!inside_next) begin
                inside_next     = 1'b1;
                open_start_next = write_pos_next;
                if (word_total_next >= WC_W'(MAX_WORDS)) begin
                    drop_next = 1'b1;
                    ovf_next  = 1'b1;
                end
            end
            if (!drop_next) begin
                if (write_pos_next < TP_W'(TEXT_DEPTH)) begin
                    txt_we    = 1'b1;
                    txt_waddr = write_pos_next[TA_W-1:0];
                    if (write_pos_next == open_start_next) begin
                        first_next = s_text_byte;
                    end
                    write_pos_next = write_pos_next + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end
        if (!is_letter || s_text_last) begin
            word_len  = write_pos_next - open_start_next;
            tbl_waddr = word_total_next[WA_W-1:0];
            if (inside_next && !drop_next && word_len != '0
                    && word_total_next < WC_W'(MAX_WORDS)) begin
                tbl_we          = 1'b1;
                word_total_next = word_total_next + 1'b1;
            end
            inside_next = 1'b0;
            drop_next   = 1'b0;
        end
        if (s_text_last) begin
            closed_next = 1'b1;
        end
        txt_we = txt_we && cmd.push;
        tbl_we = tbl_we && cmd.push;
    end

    assign tbl_wdata = {rank_cfg_reg[letter_idx * RANK_W +: RANK_W],
                        open_start_next[TA_W-1:0], word_len[TA_W-1:0] - 1'b1};
    assign txt_raddr = ent_start + read_off_reg;
    assign word_last = (read_off_reg == ent_lenm1);

    wbs_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
        .aclk  (aclk),
        .we    (txt_we),
        .waddr (txt_waddr),
        .wdata (s_text_byte),
        .re    (cmd.txt_rd),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    wbs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WORDS)) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (cmd.tbl_rd),
        .raddr (read_word_reg[WA_W-1:0]),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_cfg_reg <= '1;
        end else if (cfg_we) begin
            if (cfg_index < CFG_IDX_LAST) begin
                rank_cfg_reg[cfg_index * GROUP_W +: GROUP_W] <= cfg_data;
            end else if (cfg_index == CFG_IDX_LAST) begin
                rank_cfg_reg[GROUP_LAST * GROUP_W +: LAST_W] <= cfg_data[LAST_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_total_reg <= '0;
            write_pos_reg  <= '0;
            open_start_reg <= '0;
            inside_reg     <= 1'b0;
            drop_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
            read_rank_reg  <= '0;
            read_word_reg  <= '0;
            read_off_reg   <= '0;
        end else if (cmd.push) begin
            word_total_reg <= word_total_next;
            write_pos_reg  <= write_pos_next;
            open_start_reg <= open_start_next;
            inside_reg     <= inside_next;
            drop_reg       <= drop_next;
            closed_reg     <= closed_next;
            ovf_reg        <= ovf_next;
            if (closed_reg) begin
                read_rank_reg <= '0;
                read_word_reg <= '0;
                read_off_reg  <= '0;
            end
        end else if (cmd.next_rank) begin
            read_rank_reg <= read_rank_reg + 1'b1;
            read_word_reg <= '0;
            read_off_reg  <= '0;
        end else if (cmd.next_word) begin
            read_word_reg <= read_word_reg + 1'b1;
        end else if (cmd.emit_letter) begin
            if (word_last) begin
                read_off_reg  <= '0;
                read_word_reg <= read_word_reg + 1'b1;
            end else begin
                read_off_reg <= read_off_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_open || cmd.emit_done || cmd.emit_letter) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_open || cmd.emit_done || cmd.emit_letter) begin
            m_byte_reg <= cmd.emit_letter ? txt_rdata : 8'd0;
            m_end_reg  <= cmd.emit_letter && word_last;
            m_done_reg <= cmd.emit_done;
            m_ovf_reg  <= ovf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_word_end   = m_end_reg;
    assign m_all_done   = m_done_reg;
    assign m_overflowed = m_ovf_reg;

    assign stat.push_req   = s_valid && !s_cmd;
    assign stat.pull_req   = s_valid && s_cmd;
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.closed     = closed_reg;
    assign stat.rank_done  = (read_rank_reg == RANK_END);
    assign stat.word_avail = (read_word_reg < word_total_reg);
    assign stat.match      = ({1'b0, ent_rank} == read_rank_reg);

    `WBS_ASSERT(a_word_total, aclk, aresetn, word_total_reg <= WC_W'(MAX_WORDS), "word count past table size")
    `WBS_ASSERT(a_write_pos, aclk, aresetn, write_pos_reg <= TP_W'(TEXT_DEPTH), "write position past text store")
    `WBS_ASSERT(a_emit_free, aclk, aresetn, cmd.emit_letter |-> (closed_reg && !m_valid_reg), "letter beat with output busy or text open")
    `WBS_ASSERT(a_tbl_rd, aclk, aresetn, cmd.tbl_rd |-> (read_word_reg < word_total_reg && read_rank_reg < RANK_END), "table read outside filed words")
endmodule

>>> rtl/core/word_bucket_sort_by_first_letter_unit.sv
// Stable bucket sort of words by first-letter rank. Push beats (s_cmd 0) take
// one text byte each; runs of ASCII letters form words, filed at the end of
// each word with the rank of its first letter from the rank table (cfg_index
// 0..5, six bits per letter). After the beat with s_text_last, pull beats
// (s_cmd 1) return one letter each, rank 0 first, input order within a rank.
// For each pull the sequencer searches the word table from the current word
// (one registered read per entry) and steps to the next rank when a rank has
// no more words. Pulls while the text is open return zeros; all_done marks
// the end of the sequence. Excess letters or words are dropped and flagged on
// overflowed. Write the rank table only while the unit is idle.
module word_bucket_sort_by_first_letter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_text_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_word_end,
    output logic                        m_all_done,
    output logic                        m_overflowed,
    input  logic                        cfg_we,
    input  logic [wbs_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [wbs_pkg::GROUP_W-1:0] cfg_data
);
    import wbs_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    wbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    wbs_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_valid      (s_valid),
        .s_cmd        (s_cmd),
        .s_text_byte  (s_text_byte),
        .s_text_last  (s_text_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_word_end   (m_word_end),
        .m_all_done   (m_all_done),
        .m_overflowed (m_overflowed),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import wbs_pkg::*;

    localparam int QUIET_LIMIT = 1000000;

    typedef struct {
        logic [7:0] letter;
        logic       word_end;
        logic       all_done;
        logic       overflowed;
    } letter_beat_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_cmd = 1'b0;
    logic [7:0]          s_text_byte = 8'd0;
    logic                s_text_last = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [7:0]          m_out_byte;
    logic                m_word_end;
    logic                m_all_done;
    logic                m_overflowed;
    logic                cfg_we = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [GROUP_W-1:0]  cfg_data = '0;

    word_bucket_sort_by_first_letter_unit i_dut (.*);

    always #1 aclk = ~aclk;

    // sorter shadow state
    logic [GROUP_W-1:0] rank_cfg [0:GROUP_LAST];
    logic [7:0]  txt_mem  [0:TEXT_DEPTH-1];
    int unsigned wd_start [0:MAX_WORDS-1];
    int unsigned wd_len   [0:MAX_WORDS-1];
    logic [5:0]  wd_rank  [0:MAX_WORDS-1];
    int unsigned n_words, wr_pos, word_open_at, scan_rank, scan_word, scan_off;
    bit in_word, skip_word, closed, ovf;

    letter_beat_t pending_letters[$];
    int  errors = 0;
    int  beats_sent = 0;
    int  quiet_cycles = 0;
    int  rx_stall = 0;
    bit  no_gaps = 1'b0;

    function automatic bit is_letter(logic [7:0] b);
        return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
    endfunction

    function automatic logic [5:0] letter_rank(logic [7:0] b);
        int idx;
        logic [GROUP_W-1:0] grp;
        idx = (b >= CH_LA) ? int'(b - CH_LA) : 26 + int'(b - CH_UA);
        grp = rank_cfg[idx / 10];
        return grp[6 * (idx % 10) +: 6];
    endfunction

    function automatic void file_word();
        int unsigned len;
        if (in_word && !skip_word) begin
            len = wr_pos - word_open_at;
            if (len > 0 && n_words < MAX_WORDS && word_open_at < TEXT_DEPTH) begin
                wd_start[n_words] = word_open_at;
                wd_len[n_words]   = len;
                wd_rank[n_words]  = letter_rank(txt_mem[word_open_at]);
                n_words++;
            end
        end
        in_word   = 1'b0;
        skip_word = 1'b0;
    endfunction

    function automatic void store_byte(logic [7:0] b, bit last);
        if (closed) begin
            n_words = 0; wr_pos = 0; word_open_at = 0;
            in_word = 0; skip_word = 0; closed = 0;
            scan_rank = 0; scan_word = 0; scan_off = 0; ovf = 0;
        end
        if (is_letter(b)) begin
            if (!in_word) begin
                in_word = 1'b1;
                word_open_at = wr_pos;
                if (n_words >= MAX_WORDS) begin
                    skip_word = 1'b1;
                    ovf = 1'b1;
                end
            end
            if (!skip_word) begin
                if (wr_pos < TEXT_DEPTH) begin
                    txt_mem[wr_pos] = b;
                    wr_pos++;
                end else begin
                    ovf = 1'b1;
                end
            end
        end else begin
            file_word();
        end
        if (last) begin
            file_word();
            closed = 1'b1;
        end
    endfunction

    function automatic letter_beat_t next_letter();
        letter_beat_t r;
        int unsigned w, addr;
        bit found;
        r = '{8'd0, 1'b0, 1'b0, ovf};
        found = 0;
        w = 0;
        if (!closed) return r;
        while (scan_rank < 64) begin
            for (w = scan_word; w < n_words; w++)
                if (wd_rank[w] == scan_rank) begin
                    found = 1;
                    break;
                end
            if (found) break;
            scan_rank++;
            scan_word = 0;
            scan_off = 0;
        end
        if (!found) begin
            r.all_done = 1'b1;
            return r;
        end
        if (scan_off >= wd_len[w]) scan_off = 0;
        addr = wd_start[w] + scan_off;
        r.letter = addr < TEXT_DEPTH ? txt_mem[addr] : 8'd0;
        if (scan_off + 1 >= wd_len[w]) begin
            r.word_end = 1'b1;
            scan_off = 0;
            scan_word = w + 1;
        end else begin
            scan_off++;
            scan_word = w;
        end
        return r;
    endfunction

    function automatic int unsigned letters_left();
        int unsigned s = 0;
        for (int i = 0; i < n_words; i++) s += wd_len[i];
        return s;
    endfunction

    // result channel: random stalls, compare against the oldest expectation
    always @(posedge aclk) begin
        letter_beat_t exp_b;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_letters.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    exp_b = pending_letters.pop_front();
                    if (m_out_byte !== exp_b.letter) begin
                        $error("out_byte exp %0h got %0h", exp_b.letter, m_out_byte);
                        errors++;
                    end
                    if (m_word_end !== exp_b.word_end) begin
                        $error("word_end exp %0b got %0b", exp_b.word_end, m_word_end);
                        errors++;
                    end
                    if (m_all_done !== exp_b.all_done) begin
                        $error("all_done exp %0b got %0b", exp_b.all_done, m_all_done);
                        errors++;
                    end
                    if (m_overflowed !== exp_b.overflowed) begin
                        $error("overflowed exp %0b got %0b", exp_b.overflowed, m_overflowed);
                        errors++;
                    end
                end
                rx_stall = no_gaps ? 0 : $urandom_range(0, 18);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL word_bucket_sort_by_first_letter_unit");
            $finish;
        end
    end

    // all tasks start and end at a rising edge
    task automatic send_beat(bit cmd, logic [7:0] b, bit last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_text_byte <= b;
        s_text_last <= last;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (cmd) pending_letters.push_back(next_letter());
        else store_byte(b, last);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_letters.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(int idx, logic [GROUP_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= CIDX_W'(idx);
        cfg_data  <= val;
        @(posedge aclk);
        if (idx <= GROUP_LAST)
            rank_cfg[idx] = (idx == GROUP_LAST) ? (val & GROUP_W'(24'hFFFFFF)) : val;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [GROUP_W-1:0] rand_ranks(int top);
        logic [GROUP_W-1:0] v;
        for (int i = 0; i < 10; i++)
            v[6*i +: 6] = ($urandom_range(0, 7) == 0) ? 6'd63 : 6'($urandom_range(0, top));
        return v;
    endfunction

    task automatic load_table(int top);
        drain();
        for (int i = 0; i <= GROUP_LAST; i++) write_reg(i, rand_ranks(top));
    endtask

    task automatic load_flat(logic [GROUP_W-1:0] v);
        drain();
        for (int i = 0; i <= GROUP_LAST; i++) write_reg(i, v);
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] odd [8] = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h20, 8'h80};
        case ($urandom_range(0, 9))
            0:       return odd[$urandom_range(0, 7)];
            1:       return 8'($urandom);
            2, 3, 4: return CH_UA + 8'($urandom_range(0, 25));
            default: return CH_LA + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic pull(int n);
        repeat (n) send_beat(1'b1, 8'($urandom), 1'($urandom));
    endtask

    task automatic read_all();
        pull(letters_left() + 2);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i], i == s.len() - 1);
    endtask

    task automatic test_default_ranks();
        send_string("ab Cd,ef");
        read_all();
    endtask

    task automatic test_pull_while_open();
        send_beat(1'b0, "x", 1'b0);
        pull(2);
        send_beat(1'b0, "y", 1'b1);
        read_all();
    endtask

    task automatic test_byte_extremes();
        logic [7:0] seq [12] = '{8'h00, "a", "z", 8'h40, "A", "Z", 8'h5B, 8'h60,
                                 8'h7B, "Z", "a", 8'hFF};
        load_table(63);
        foreach (seq[i]) send_beat(1'b0, seq[i], i == 11);
        read_all();
        send_beat(1'b0, 8'h20, 1'b1);   // text with no word
        pull(2);
        send_beat(1'b0, "q", 1'b1);     // one-letter text ending on a letter
        pull(3);
    endtask

    task automatic test_register_extremes();
        load_flat('0);
        send_string("bb aa cc");
        read_all();
        load_flat('1);
        write_reg(6, '0);
        write_reg(7, '0);
        send_string("Zq Yp ab");
        read_all();
    endtask

    task automatic test_text_full();
        load_flat('0);
        no_gaps = 1'b1;
        for (int i = 0; i < TEXT_DEPTH + 4; i++)
            send_beat(1'b0, CH_LA + 8'(i % 26), 1'b0);
        send_string(" tail");
        no_gaps = 1'b0;
        pull(6);
    endtask

    task automatic test_table_full();
        no_gaps = 1'b1;
        for (int i = 0; i < MAX_WORDS + 3; i++) begin
            send_beat(1'b0, CH_UA + 8'(i % 26), 1'b0);
            send_beat(1'b0, 8'h2E, i == MAX_WORDS + 2);
        end
        no_gaps = 1'b0;
        pull(6);
    endtask

    task automatic test_random_texts();
        int n, base;
        base = beats_sent;
        while (beats_sent - base < 800) begin
            if ($urandom_range(0, 5) == 0)
                load_table($urandom_range(0, 3) == 0 ? 63 : $urandom_range(0, 4));
            no_gaps = ($urandom_range(0, 4) == 0);
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0) pull(1);
                send_beat(1'b0, rand_text_byte(), i == n - 1);
            end
            if ($urandom_range(0, 4) == 0) pull($urandom_range(0, 5));
            else read_all();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < GROUP_LAST; i++) rank_cfg[i] = '1;
        rank_cfg[GROUP_LAST] = GROUP_W'(24'hFFFFFF);
        n_words = 0; wr_pos = 0; word_open_at = 0; scan_rank = 0; scan_word = 0;
        scan_off = 0; in_word = 0; skip_word = 0; closed = 0; ovf = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_ranks();
        test_pull_while_open();
        test_byte_extremes();
        test_register_extremes();
        test_text_full();
        test_table_full();
        test_random_texts();
        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_letters.size() == 0)
            $display("PASS word_bucket_sort_by_first_letter_unit");
        else
            $display("FAIL word_bucket_sort_by_first_letter_unit");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/wbs_pkg.sv
rtl/core/wbs_ram.sv
rtl/core/wbs_ctrl.sv
rtl/core/wbs_dp.sv
rtl/core/word_bucket_sort_by_first_letter_unit.sv
sim/testbench.sv
